// ===== rtl/core/rdsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsgd_pkg
// shared types and constants of the rds group decoder
// ----------------------------------------------------------------------------
package rdsgd_pkg;

    localparam int PS_LEN = 8;
    localparam int POS_W  = 7;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [3:0] GTYPE_BASIC = 4'd0;
    localparam logic [3:0] GTYPE_RT    = 4'd2;
    localparam logic [3:0] GTYPE_EON   = 4'd14;
    localparam logic [3:0] GTYPE_FAST  = 4'd15;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_PTY    = 3'd1;
    localparam logic [2:0] KIND_TA     = 3'd2;
    localparam logic [2:0] KIND_PS     = 3'd3;
    localparam logic [2:0] KIND_RT     = 3'd4;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_STAT,
        S_PTY,
        S_DISP,
        S_TA,
        S_PS_WR,
        S_PS_CMP,
        S_PS_EMIT,
        S_RT_WR,
        S_RT_CMP,
        S_RT_RD,
        S_RT_CAP,
        S_RT_OUT,
        S_FIN
    } rdsgd_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] prog_ident;
        logic        traffic_program;
        logic        music_speech;
        logic [5:0]  char_offset;
        logic [7:0]  char0;
        logic [7:0]  char1;
        logic [7:0]  char2;
        logic [7:0]  char3;
        logic [2:0]  chars_valid;
    } rdsgd_res_t;

    typedef struct packed {
        logic emit;
        logic finish;
    } rdsgd_ost_ctl_t;

    typedef struct packed {
        logic can_emit;
        logic slot_free;
    } rdsgd_ost_sts_t;

    typedef struct packed {
        logic             clear;
        logic             asm_we;
        logic             ver;
        logic             ab;
        logic [POS_W-1:0] wpos;
        logic [7:0]       wdata;
        logic [POS_W-1:0] rpos;
        logic             shown_we;
        logic [POS_W-1:0] spos;
    } rdsgd_mem_req_t;

endpackage

// ===== rtl/core/rdsgd_text_mem.sv =====
// ----------------------------------------------------------------------------
// rdsgd_text_mem
// radiotext assembly and shown-text memories with registered reads
// ----------------------------------------------------------------------------
module rdsgd_text_mem #(
    parameter int RT_A_LEN = 64,
    parameter int RT_B_LEN = 32
) (
    input  logic                    clk,
    input  rdsgd_pkg::rdsgd_mem_req_t req,
    output logic [7:0]              asm_rdata,
    output logic [7:0]              shown_rdata
);
    import rdsgd_pkg::*;

    localparam int RTA_DEPTH = 2 * RT_A_LEN;
    localparam int RTA_AW    = $clog2(RTA_DEPTH);
    localparam int RSA_AW    = $clog2(RT_A_LEN);
    localparam int RB_AW     = $clog2(RT_B_LEN);

    logic [7:0] rta_mem [RTA_DEPTH];
    logic [7:0] rsa_mem [RT_A_LEN];
    logic [7:0] rtb_mem [RT_B_LEN];
    logic [7:0] rsb_mem [RT_B_LEN];

    logic [7:0] a_rd_reg, sa_rd_reg, b_rd_reg, sb_rd_reg;
    logic [RTA_AW-1:0] wa_addr, ra_addr;
    logic a_in, b_in;

    // two halves of the a-text store, one per text a/b flag
    assign wa_addr = req.ab ? RTA_AW'(req.wpos) + RTA_AW'(RT_A_LEN) : RTA_AW'(req.wpos);
    assign ra_addr = req.ab ? RTA_AW'(req.rpos) + RTA_AW'(RT_A_LEN) : RTA_AW'(req.rpos);
    assign a_in    = req.wpos < POS_W'(RT_A_LEN);
    assign b_in    = req.wpos < POS_W'(RT_B_LEN);

    always_ff @(posedge clk)
    begin
        if (req.clear)
        begin
            if (a_in)
            begin
                rta_mem[wa_addr]               <= 8'h00;
                rsa_mem[req.wpos[RSA_AW-1:0]]  <= 8'h00;
            end
            if (b_in)
            begin
                rtb_mem[req.wpos[RB_AW-1:0]] <= 8'h00;
                rsb_mem[req.wpos[RB_AW-1:0]] <= 8'h00;
            end
        end
        else
        begin
            if (req.asm_we && !req.ver && a_in)
                rta_mem[wa_addr] <= req.wdata;
            if (req.asm_we && req.ver && b_in)
                rtb_mem[req.wpos[RB_AW-1:0]] <= req.wdata;
            // copy of the assembly byte read in the previous cycle
            if (req.shown_we && !req.ver)
                rsa_mem[req.spos[RSA_AW-1:0]] <= a_rd_reg;
            if (req.shown_we && req.ver)
                rsb_mem[req.spos[RB_AW-1:0]] <= b_rd_reg;
        end
        a_rd_reg  <= rta_mem[ra_addr];
        sa_rd_reg <= rsa_mem[req.rpos[RSA_AW-1:0]];
        b_rd_reg  <= rtb_mem[req.rpos[RB_AW-1:0]];
        sb_rd_reg <= rsb_mem[req.rpos[RB_AW-1:0]];
    end

    assign asm_rdata   = req.ver ? b_rd_reg  : a_rd_reg;
    assign shown_rdata = req.ver ? sb_rd_reg : sa_rd_reg;

endmodule

// ===== rtl/core/rdsgd_out_stage.sv =====
// ----------------------------------------------------------------------------
// rdsgd_out_stage
// one-word hold stage that marks the final word, then the output register
// ----------------------------------------------------------------------------
module rdsgd_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rdsgd_pkg::rdsgd_ost_ctl_t ctl,
    input  rdsgd_pkg::rdsgd_res_t     word,
    output rdsgd_pkg::rdsgd_ost_sts_t sts,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [63:0]             m_tdata,  // prog_ident, traffic_program, music_speech,
                                              // char_offset, char0..char3, chars_valid, zeros
    output logic [2:0]              m_tuser,  // kind
    output logic                    m_tlast   // last
);
    import rdsgd_pkg::*;

    rdsgd_res_t hold_reg, out_reg;
    logic       hold_v_reg, out_v_reg, out_last_reg;
    logic       slot_free, can_emit;

    assign slot_free = !out_v_reg || m_tready;
    assign can_emit  = !hold_v_reg || slot_free;
    assign sts       = '{can_emit: can_emit, slot_free: slot_free};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= '0;
            out_reg      <= '0;
            hold_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (ctl.emit && can_emit)
            begin
                hold_reg   <= word;
                hold_v_reg <= 1'b1;
                if (hold_v_reg)
                begin
                    out_reg      <= hold_reg;
                    out_last_reg <= 1'b0;
                    out_v_reg    <= 1'b1;
                end
                else if (m_tready)
                    out_v_reg <= 1'b0;
            end
            else if (ctl.finish && slot_free && hold_v_reg)
            begin
                out_reg      <= hold_reg;
                out_last_reg <= 1'b1;
                out_v_reg    <= 1'b1;
                hold_v_reg   <= 1'b0;
            end
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_reg.chars_valid, out_reg.char3, out_reg.char2,
                       out_reg.char1, out_reg.char0, out_reg.char_offset,
                       out_reg.music_speech, out_reg.traffic_program, out_reg.prog_ident};

endmodule

// ===== rtl/core/rds_group_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rds_group_decoder_core
// decodes one rds group per input word into status, event and text words
// ----------------------------------------------------------------------------
// each input word is one group (blocks a to d). the block answers with a
// status word, then a pty change and a ta change word where due, then the ps
// name in two 4-char words when a completed name differs from the one last
// shown, and radiotext in words of one to 4 chars when a terminated text
// differs from the one last shown; tlast marks the final word of a group.
// one small sequencer walks every group while s_tready is low. the single
// read port of the text memories sets the radiotext steps: one compare per
// cycle, then one read and one capture per character sent. after reset a
// clearing pass over both halves of the text memories zeroes them before
// the first group is taken.
// ----------------------------------------------------------------------------
module rds_group_decoder_core #(
    parameter int RT_A_LEN = 64,
    parameter int RT_B_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // block_a, block_b, block_c, block_d
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // prog_ident, traffic_program, music_speech,
                                   // char_offset, char0..char3, chars_valid, zeros
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);
    import rdsgd_pkg::*;

    localparam int MAX_LEN = (RT_A_LEN > RT_B_LEN) ? RT_A_LEN : RT_B_LEN;

    rdsgd_state_t state_reg, state_next;

    // group word and decoder state
    logic [15:0] b_reg, c_reg, d_reg;
    logic [15:0] last_pi_reg;
    logic [4:0]  last_pty_reg;
    logic        tp_reg, ms_reg, ta_active_reg, pty_chg_reg, ta_on_reg, clr_ab_reg;
    logic [2:0]  ps_seg_cnt_reg;
    logic [4:0]  rt_seg_cnt_reg;
    logic [PS_LEN-1:0][7:0] ps_asm_reg [2];
    logic [PS_LEN-1:0][7:0] ps_shown_reg;

    // radiotext walk
    logic [POS_W-1:0] idx_reg, len_reg, cmp_pos_reg;
    logic             ended_reg, diff_reg, rd_pend_reg;
    logic [3:0][7:0]  chunk_reg;

    rdsgd_res_t     word;
    rdsgd_ost_ctl_t ost_ctl;
    rdsgd_ost_sts_t ost_sts;
    rdsgd_mem_req_t mreq;
    logic [7:0]     asm_rdata, shown_rdata;

    logic        accept;
    logic [3:0]  gtype;
    logic        ver;
    logic [1:0]  ps_seg;
    logic [3:0]  rt_seg;
    logic [2:0]  ps_cnt_eff;
    logic [4:0]  rt_cnt_eff;
    logic        ps_ok, rt_ok;
    logic [POS_W-1:0] rt_pos, rt_lim, cap_last, rt_base;
    logic [7:0]  rt_byte;
    logic        rt_in, rt_term, rt_last_i;
    logic [2:0]  rt_valid;
    logic [2:0]  ps_base;

    assign accept = s_tvalid && s_tready;
    assign gtype  = b_reg[15:12];
    assign ver    = b_reg[11];
    assign ps_seg = b_reg[1:0];
    assign rt_seg = b_reg[3:0];

    // segment zero restarts assembly; other segments must match the count
    assign ps_cnt_eff = (ps_seg == 2'd0) ? 3'd0 : ps_seg_cnt_reg;
    assign rt_cnt_eff = (rt_seg == 4'd0) ? 5'd0 : rt_seg_cnt_reg;
    assign ps_ok      = (ps_seg == 2'd0) || (ps_cnt_eff == {1'b0, ps_seg});
    assign rt_ok      = (rt_seg == 4'd0) || (rt_cnt_eff == {1'b0, rt_seg});

    // radiotext byte under the write walk
    always_comb
    begin
        if (!ver)
        begin
            rt_pos = {1'b0, rt_seg, idx_reg[1:0]};
            rt_lim = POS_W'(RT_A_LEN);
            unique case (idx_reg[1:0])
                2'd0:    rt_byte = c_reg[15:8];
                2'd1:    rt_byte = c_reg[7:0];
                2'd2:    rt_byte = d_reg[15:8];
                default: rt_byte = d_reg[7:0];
            endcase
            rt_last_i = (idx_reg[1:0] == 2'd3);
        end
        else
        begin
            rt_pos    = {2'b0, rt_seg, idx_reg[0]};
            rt_lim    = POS_W'(RT_B_LEN);
            rt_byte   = idx_reg[0] ? d_reg[7:0] : d_reg[15:8];
            rt_last_i = idx_reg[0];
        end
    end

    assign rt_in   = rt_pos < rt_lim;
    // only the first terminator of a group ends the text
    assign rt_term = rt_in && !ended_reg &&
                     ((rt_byte == CHAR_CR) || (rt_pos == rt_lim - POS_W'(1)));

    assign cap_last = idx_reg - POS_W'(1);
    assign rt_base  = {cap_last[POS_W-1:2], 2'b00};
    assign rt_valid = 3'(idx_reg - rt_base);
    assign ps_base  = {idx_reg[0], 2'b00};

    // sequencer: next state, emitted word, memory requests
    always_comb
    begin
        state_next = state_reg;
        ost_ctl    = '0;
        mreq       = '0;
        mreq.ver   = ver;
        mreq.ab    = b_reg[4];
        word                 = '0;
        word.prog_ident      = last_pi_reg;
        word.traffic_program = tp_reg;
        word.music_speech    = ms_reg;
        word.chars_valid     = 3'd1;

        unique case (state_reg)
            S_CLR:
            begin
                mreq.clear = 1'b1;
                mreq.ab    = clr_ab_reg;
                mreq.wpos  = idx_reg;
                if (idx_reg == POS_W'(MAX_LEN - 1) && clr_ab_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = S_STAT;
            end
            S_STAT:
            begin
                ost_ctl.emit = 1'b1;
                word.kind    = KIND_STATUS;
                word.char0   = {3'b0, last_pty_reg};
                if (ost_sts.can_emit)
                    state_next = pty_chg_reg ? S_PTY : S_DISP;
            end
            S_PTY:
            begin
                ost_ctl.emit = 1'b1;
                word.kind    = KIND_PTY;
                word.char0   = {3'b0, last_pty_reg};
                if (ost_sts.can_emit)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                priority if (gtype == GTYPE_BASIC)
                    state_next = ps_ok ? S_TA : S_FIN;
                else if (gtype == GTYPE_RT)
                    state_next = rt_ok ? S_RT_WR : S_FIN;
                else if (gtype == GTYPE_EON && ver)
                    state_next = S_TA;
                else
                    state_next = S_FIN;
            end
            S_TA:
            begin
                word.kind  = KIND_TA;
                word.char0 = {7'b0, ta_on_reg};
                if (ta_on_reg != ta_active_reg)
                begin
                    ost_ctl.emit = 1'b1;
                    if (ost_sts.can_emit)
                        state_next = (gtype == GTYPE_BASIC) ? S_PS_WR : S_FIN;
                end
                else
                    state_next = (gtype == GTYPE_BASIC) ? S_PS_WR : S_FIN;
            end
            S_PS_WR:
            begin
                state_next = (ps_seg == 2'd3) ? S_PS_CMP : S_FIN;
            end
            S_PS_CMP:
            begin
                state_next = (ps_asm_reg[ver] != ps_shown_reg) ? S_PS_EMIT : S_FIN;
            end
            S_PS_EMIT:
            begin
                ost_ctl.emit     = 1'b1;
                word.kind        = KIND_PS;
                word.char_offset = {3'b0, ps_base};
                word.char0       = ps_shown_reg[ps_base];
                word.char1       = ps_shown_reg[ps_base + 3'd1];
                word.char2       = ps_shown_reg[ps_base + 3'd2];
                word.char3       = ps_shown_reg[ps_base + 3'd3];
                word.chars_valid = 3'd4;
                if (ost_sts.can_emit && idx_reg[0])
                    state_next = S_FIN;
            end
            S_RT_WR:
            begin
                mreq.asm_we = rt_in;
                mreq.wpos   = rt_pos;
                mreq.wdata  = rt_byte;
                if (rt_last_i)
                    state_next = (ended_reg || rt_term) ? S_RT_CMP : S_FIN;
            end
            S_RT_CMP:
            begin
                mreq.rpos     = idx_reg;
                mreq.shown_we = rd_pend_reg;
                mreq.spos     = cmp_pos_reg;
                if (idx_reg == len_reg && !rd_pend_reg)
                    state_next = diff_reg ? S_RT_RD : S_FIN;
            end
            S_RT_RD:
            begin
                mreq.rpos  = idx_reg;
                state_next = S_RT_CAP;
            end
            S_RT_CAP:
            begin
                mreq.rpos = idx_reg;
                if (idx_reg[1:0] == 2'd3 || idx_reg + POS_W'(1) == len_reg)
                    state_next = S_RT_OUT;
                else
                    state_next = S_RT_RD;
            end
            S_RT_OUT:
            begin
                ost_ctl.emit     = 1'b1;
                word.kind        = KIND_RT;
                word.char_offset = rt_base[5:0];
                word.char0       = chunk_reg[0];
                word.char1       = chunk_reg[1];
                word.char2       = chunk_reg[2];
                word.char3       = chunk_reg[3];
                word.chars_valid = rt_valid;
                if (ost_sts.can_emit)
                    state_next = (idx_reg == len_reg) ? S_FIN : S_RT_RD;
            end
            S_FIN:
            begin
                ost_ctl.finish = 1'b1;
                if (ost_sts.slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    // datapath registers stepped by the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg          <= '0;
            c_reg          <= '0;
            d_reg          <= '0;
            last_pi_reg    <= '0;
            last_pty_reg   <= '0;
            tp_reg         <= 1'b0;
            ms_reg         <= 1'b0;
            ta_active_reg  <= 1'b0;
            pty_chg_reg    <= 1'b0;
            ta_on_reg      <= 1'b0;
            clr_ab_reg     <= 1'b0;
            ps_seg_cnt_reg <= '0;
            rt_seg_cnt_reg <= '0;
            ps_asm_reg[0]  <= '0;
            ps_asm_reg[1]  <= '0;
            ps_shown_reg   <= '0;
            idx_reg        <= '0;
            len_reg        <= '0;
            cmp_pos_reg    <= '0;
            ended_reg      <= 1'b0;
            diff_reg       <= 1'b0;
            rd_pend_reg    <= 1'b0;
            chunk_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    if (idx_reg == POS_W'(MAX_LEN - 1))
                    begin
                        idx_reg    <= '0;
                        clr_ab_reg <= 1'b1;
                    end
                    else
                        idx_reg <= idx_reg + POS_W'(1);
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_pi_reg  <= s_tdata[15:0];
                        b_reg        <= s_tdata[31:16];
                        c_reg        <= s_tdata[47:32];
                        d_reg        <= s_tdata[63:48];
                        pty_chg_reg  <= (s_tdata[25:21] != last_pty_reg);
                        last_pty_reg <= s_tdata[25:21];
                        tp_reg       <= s_tdata[26];
                        // ms only from groups 0a, 0b and 15b
                        if (s_tdata[31:28] == GTYPE_BASIC ||
                            (s_tdata[31:28] == GTYPE_FAST && s_tdata[27]))
                            ms_reg <= s_tdata[19];
                    end
                end
                S_DISP:
                begin
                    priority if (gtype == GTYPE_BASIC)
                    begin
                        ps_seg_cnt_reg <= ps_cnt_eff;
                        ta_on_reg      <= b_reg[4] && b_reg[10];
                    end
                    else if (gtype == GTYPE_RT)
                    begin
                        rt_seg_cnt_reg <= rt_cnt_eff;
                        idx_reg        <= '0;
                        len_reg        <= '0;
                        ended_reg      <= 1'b0;
                    end
                    else
                        ta_on_reg <= (b_reg[4:3] == 2'b11);
                end
                S_TA:
                begin
                    if (ost_sts.can_emit)
                        ta_active_reg <= ta_on_reg;
                end
                S_PS_WR:
                begin
                    ps_asm_reg[ver][{ps_seg, 1'b0}] <= d_reg[15:8];
                    ps_asm_reg[ver][{ps_seg, 1'b1}] <= d_reg[7:0];
                    ps_seg_cnt_reg <= ps_seg_cnt_reg + 3'd1;
                end
                S_PS_CMP:
                begin
                    ps_shown_reg <= ps_asm_reg[ver];
                    idx_reg      <= '0;
                end
                S_PS_EMIT:
                begin
                    if (ost_sts.can_emit)
                        idx_reg <= idx_reg + POS_W'(1);
                end
                S_RT_WR:
                begin
                    if (rt_term)
                    begin
                        ended_reg <= 1'b1;
                        len_reg   <= rt_pos + POS_W'(1);
                    end
                    if (rt_last_i)
                    begin
                        rt_seg_cnt_reg <= rt_seg_cnt_reg + 5'd1;
                        idx_reg        <= '0;
                        diff_reg       <= 1'b0;
                        rd_pend_reg    <= 1'b0;
                    end
                    else
                        idx_reg <= idx_reg + POS_W'(1);
                end
                S_RT_CMP:
                begin
                    // compare and copy one byte behind the read address
                    rd_pend_reg <= (idx_reg < len_reg);
                    cmp_pos_reg <= idx_reg;
                    if (idx_reg < len_reg)
                        idx_reg <= idx_reg + POS_W'(1);
                    if (rd_pend_reg && (asm_rdata != shown_rdata))
                        diff_reg <= 1'b1;
                    if (idx_reg == len_reg && !rd_pend_reg)
                    begin
                        idx_reg   <= '0;
                        chunk_reg <= '0;
                    end
                end
                S_RT_CAP:
                begin
                    chunk_reg[idx_reg[1:0]] <= asm_rdata;
                    idx_reg                 <= idx_reg + POS_W'(1);
                end
                S_RT_OUT:
                begin
                    if (ost_sts.can_emit)
                        chunk_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    rdsgd_text_mem #(
        .RT_A_LEN (RT_A_LEN),
        .RT_B_LEN (RT_B_LEN)
    ) u_mem (
        .clk         (clk),
        .req         (mreq),
        .asm_rdata   (asm_rdata),
        .shown_rdata (shown_rdata)
    );

    rdsgd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ost_ctl),
        .word     (word),
        .sts      (ost_sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // an accepted group always starts with its status word
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_STAT)
        else $error("group accepted without status step");

    // a text chunk carries one to four characters
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RT_OUT |-> (rt_valid != 3'd0 && rt_valid <= 3'd4))
        else $error("radiotext chunk size out of range");

    // compare walk never runs past the terminated length
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RT_CMP |-> (idx_reg <= len_reg && len_reg != '0))
        else $error("radiotext compare index beyond length");

    // the hold stage is drained once a group has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && ost_sts.slot_free) |=> !ost_sts.can_emit == 1'b0)
        else $error("hold stage not drained at end of group");

endmodule
